### rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and register indexes shared by the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned MaxDelay = 65536;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned AddrW    = $clog2(MaxDelay);
  localparam int unsigned LenW     = AddrW + 1;
  localparam int unsigned GainW    = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = LenW;

  // Output queue of result pairs.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegDelayLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFeedbackGain = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegDryGain      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegWetGain      = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegBypass       = CfgIdxW'(4);

  // Register values after reset.
  localparam logic [LenW-1:0]  RstDelayLength = LenW'(44100);
  localparam logic [GainW-1:0] RstGain        = GainW'(128);

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxDelay);

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  localparam int unsigned PairW = $bits(pair_t);

endpackage

### rtl/core/sfd_in_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if
// Input stream: one left/right sample pair per transfer.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic              valid;
  logic              ready;
  sfd_pkg::sample_t  left_in;
  sfd_pkg::sample_t  right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

### rtl/core/sfd_out_if.sv
// ----------------------------------------------------------------------------
// sfd_out_if
// Output stream: one left/right result pair per transfer.
// ----------------------------------------------------------------------------
interface sfd_out_if;
  logic              valid;
  logic              ready;
  sfd_pkg::sample_t  left_out;
  sfd_pkg::sample_t  right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### rtl/core/stereo_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo echo: per channel, out = dry*in + wet*delayed and the line keeps
// in + feedback*delayed, with one shared position in a single line memory.
// ----------------------------------------------------------------------------
// The block takes one left/right pair per clock cycle and keeps that rate as
// long as the output side takes results; a result passes the second-stage
// registers and then the result queue. Both delay lines share one 65536-entry
// memory with 32-bit words, read when the pair is accepted and written back in
// the next cycle; when the position wraps onto the entry just being written,
// the new value is forwarded. A four-entry result queue separates the two
// sides, so input keeps flowing while a result waits. Writing delay_length
// clears the lines at once by resetting a fill count (entries not yet written
// since then read as zero), so there is no clearing pass and no dead time.
// Configuration must be written only while no item is in flight.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sfd_in_if.sink                        in_i,
  sfd_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfd_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW = sfd_pkg::AddrW;
  localparam int unsigned LenW  = sfd_pkg::LenW;
  localparam int unsigned GainW = sfd_pkg::GainW;

  // Configuration registers.
  logic [LenW-1:0]  len_q;
  logic [GainW-1:0] fb_q, dry_q, wet_q;
  logic             byp_q;
  logic             len_wr;

  // Front end: position and fill count.
  logic [AddrW-1:0] pos_q, pos_d, pos_cur;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]  act_len, pos_inc;
  logic             accept, issue;

  // Second stage.
  logic                 s1_v_q, s1_byp_q, s1_hit_q, s1_fwd_q;
  sfd_pkg::pair_t       s1_x_q, fwd_data_q, s1_d, rd_pair;
  logic [AddrW-1:0]     s1_addr_q;
  sfd_pkg::pair_t       y_pair, st_pair, res_pair;
  logic [sfd_pkg::PairW-1:0] ram_rdata;
  logic                 ram_we;

  // Queue.
  logic [sfd_pkg::FifoCntW-1:0] fifo_cnt;
  logic [sfd_pkg::FifoCntW:0]   in_flight;
  sfd_pkg::pair_t               fifo_data;

  assign len_wr = cfg_we_i && (cfg_idx_i == sfd_pkg::RegDelayLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= sfd_pkg::RstDelayLength;
      fb_q  <= sfd_pkg::RstGain;
      dry_q <= sfd_pkg::RstGain;
      wet_q <= sfd_pkg::RstGain;
      byp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::RegDelayLength:  len_q <= cfg_data_i[LenW-1:0];
        sfd_pkg::RegFeedbackGain: fb_q  <= cfg_data_i[GainW-1:0];
        sfd_pkg::RegDryGain:      dry_q <= cfg_data_i[GainW-1:0];
        sfd_pkg::RegWetGain:      wet_q <= cfg_data_i[GainW-1:0];
        sfd_pkg::RegBypass:       byp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the memory depth as the full depth.
  always_comb begin
    if (len_q == '0) begin
      act_len = LenW'(1);
    end else if (len_q > sfd_pkg::MaxLen) begin
      act_len = sfd_pkg::MaxLen;
    end else begin
      act_len = len_q;
    end
  end

  // Slots in the queue are reserved by items still in the second stage.
  assign in_flight = {1'b0, fifo_cnt} + (sfd_pkg::FifoCntW+1)'(s1_v_q);
  assign in_i.ready = (in_flight < (sfd_pkg::FifoCntW+1)'(sfd_pkg::FifoDepth));
  assign accept = in_i.valid && in_i.ready;
  assign issue  = accept && !byp_q;

  assign pos_cur = ({1'b0, pos_q} >= act_len) ? '0 : pos_q;
  assign pos_inc = {1'b0, pos_cur} + LenW'(1);

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (issue) begin
      pos_d = (pos_inc >= act_len) ? '0 : pos_inc[AddrW-1:0];
      // Entries are written in order from zero, so the fill count tracks
      // which ones hold data since the last clear.
      if ({1'b0, pos_cur} == fill_q) begin
        fill_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else if (len_wr) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_byp_q <= 1'b0;
      s1_hit_q <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else begin
      s1_v_q   <= accept;
      s1_byp_q <= byp_q;
      s1_hit_q <= ({1'b0, pos_cur} < fill_q);
      s1_fwd_q <= issue && ram_we && (s1_addr_q == pos_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= '{left: in_i.left_in, right: in_i.right_in};
      s1_addr_q <= pos_cur;
    end
    fwd_data_q <= st_pair;
  end

  sfd_ram #(
    .Width (sfd_pkg::PairW),
    .Depth (sfd_pkg::MaxDelay)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (st_pair),
    .re_i    (issue),
    .raddr_i (pos_cur),
    .rdata_o (ram_rdata)
  );

  assign ram_we  = s1_v_q && !s1_byp_q;
  assign rd_pair = sfd_pkg::pair_t'(ram_rdata);

  always_comb begin
    if (s1_fwd_q) begin
      s1_d = fwd_data_q;
    end else if (s1_hit_q) begin
      s1_d = rd_pair;
    end else begin
      s1_d = '0;
    end
  end

  sfd_chan u_chan_left (
    .x_i   (s1_x_q.left),
    .d_i   (s1_d.left),
    .dry_i (dry_q),
    .wet_i (wet_q),
    .fb_i  (fb_q),
    .y_o   (y_pair.left),
    .st_o  (st_pair.left)
  );

  sfd_chan u_chan_right (
    .x_i   (s1_x_q.right),
    .d_i   (s1_d.right),
    .dry_i (dry_q),
    .wet_i (wet_q),
    .fb_i  (fb_q),
    .y_o   (y_pair.right),
    .st_o  (st_pair.right)
  );

  assign res_pair = s1_byp_q ? s1_x_q : y_pair;

  sfd_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_v_q),
    .data_i  (res_pair),
    .pop_i   (out_o.ready),
    .valid_o (out_o.valid),
    .data_o  (fifo_data),
    .count_o (fifo_cnt)
  );

  assign out_o.left_out  = fifo_data.left;
  assign out_o.right_out = fifo_data.right;

endmodule

### rtl/core/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sfd_chan.sv
// ----------------------------------------------------------------------------
// sfd_chan
// Per-channel arithmetic: output mix and the value written back to the line,
// both rounded half up from Q.8 and saturated to the sample range.
// ----------------------------------------------------------------------------
module sfd_chan (
  input  sfd_pkg::sample_t                x_i,
  input  sfd_pkg::sample_t                d_i,
  input  logic [sfd_pkg::GainW-1:0]       dry_i,
  input  logic [sfd_pkg::GainW-1:0]       wet_i,
  input  logic [sfd_pkg::GainW-1:0]       fb_i,
  output sfd_pkg::sample_t                y_o,
  output sfd_pkg::sample_t                st_o
);

  localparam int unsigned AccW = sfd_pkg::SampleW + sfd_pkg::GainW + 2;
  localparam int unsigned QW   = AccW - 8;

  logic signed [AccW-1:0] x_e, d_e, dry_e, wet_e, fb_e;
  logic signed [AccW-1:0] mix_acc, st_acc;

  function automatic sfd_pkg::sample_t round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] v;
    logic signed [QW-1:0]   q;
    logic signed [QW-1:0]   hi;
    logic signed [QW-1:0]   lo;
    sfd_pkg::sample_t       r;
    v  = acc + AccW'(128);
    q  = QW'(v >>> 8);
    hi = QW'({1'b0, {(sfd_pkg::SampleW-1){1'b1}}});
    lo = -hi - QW'(1);
    if (q > hi) begin
      r = {1'b0, {(sfd_pkg::SampleW-1){1'b1}}};
    end else if (q < lo) begin
      r = {1'b1, {(sfd_pkg::SampleW-1){1'b0}}};
    end else begin
      r = sfd_pkg::SampleW'(q);
    end
    return r;
  endfunction

  assign x_e   = AccW'(x_i);
  assign d_e   = AccW'(d_i);
  assign dry_e = {{(AccW-sfd_pkg::GainW){1'b0}}, dry_i};
  assign wet_e = {{(AccW-sfd_pkg::GainW){1'b0}}, wet_i};
  assign fb_e  = {{(AccW-sfd_pkg::GainW){1'b0}}, fb_i};

  assign mix_acc = x_e * dry_e + d_e * wet_e;
  assign st_acc  = (x_e <<< 8) + d_e * fb_e;

  assign y_o  = round_sat(mix_acc);
  assign st_o = round_sat(st_acc);

endmodule

### rtl/core/sfd_fifo.sv
// ----------------------------------------------------------------------------
// sfd_fifo
// Small output queue of result pairs; it reports its fill level so the
// front end can issue only when a slot is guaranteed.
// ----------------------------------------------------------------------------
module sfd_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  sfd_pkg::pair_t                data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output sfd_pkg::pair_t                data_o,
  output logic [sfd_pkg::FifoCntW-1:0]  count_o
);

  sfd_pkg::pair_t                  buf_q [sfd_pkg::FifoDepth];
  logic [sfd_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [sfd_pkg::FifoCntW-1:0]    cnt_q, cnt_d;
  logic                            do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + sfd_pkg::FifoCntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - sfd_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + sfd_pkg::FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + sfd_pkg::FifoPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
